>>> hw/rtl/button_debounce_autorepeat_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define BDA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define BDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BDA_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BDA_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and codes of the button debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package bda_pkg;

    // debounce machine
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESS   = 2'd1,
        MODE_HELD    = 2'd2,
        MODE_RELEASE = 2'd3
    } mode_t;

    localparam int CODE_WIDTH   = 4;
    localparam int LEVELS_WIDTH = 2;

    localparam logic [CODE_WIDTH-1:0]   CODE_INC  = 4'd4;
    localparam logic [CODE_WIDTH-1:0]   CODE_NEXT = 4'd8;
    localparam logic [LEVELS_WIDTH-1:0] LEVELS_UP = 2'd3;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_VALUE       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_VALUE       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_SETTLE    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_SETTLE  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPEAT_TICKS    = 3'd4;

    // status flags of one result beat
    typedef struct packed {
        logic edges_armed;
        logic next_requested;
        logic display_written;
    } res_flags_t;

endpackage

>>> hw/rtl/bda_cfg.sv
// ----------------------------------------------------------------------------
// bda_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module bda_cfg #(
    parameter int VALUE_WIDTH      = 8,
    parameter int TICK_COUNT_WIDTH = 6,
    parameter int CFG_DATA_WIDTH   = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [bda_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]            cfg_wdata,
    output logic [VALUE_WIDTH-1:0]               min_value,
    output logic [VALUE_WIDTH-1:0]               max_value,
    output logic [TICK_COUNT_WIDTH-1:0]          press_settle_ticks,
    output logic [TICK_COUNT_WIDTH-1:0]          release_settle_ticks,
    output logic [TICK_COUNT_WIDTH-1:0]          repeat_ticks
);

    logic [VALUE_WIDTH-1:0]      min_value_reg;
    logic [VALUE_WIDTH-1:0]      max_value_reg;
    logic [TICK_COUNT_WIDTH-1:0] press_settle_reg;
    logic [TICK_COUNT_WIDTH-1:0] release_settle_reg;
    logic [TICK_COUNT_WIDTH-1:0] repeat_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg      <= '0;
            max_value_reg      <= VALUE_WIDTH'(16);
            press_settle_reg   <= TICK_COUNT_WIDTH'(15);
            release_settle_reg <= TICK_COUNT_WIDTH'(20);
            repeat_ticks_reg   <= TICK_COUNT_WIDTH'(30);
        end else if (cfg_we) begin
            case (cfg_index)
                bda_pkg::CFG_MIN_VALUE: begin
                    min_value_reg <= cfg_wdata[VALUE_WIDTH-1:0];
                end
                bda_pkg::CFG_MAX_VALUE: begin
                    max_value_reg <= cfg_wdata[VALUE_WIDTH-1:0];
                end
                bda_pkg::CFG_PRESS_SETTLE: begin
                    press_settle_reg <= cfg_wdata[TICK_COUNT_WIDTH-1:0];
                end
                bda_pkg::CFG_RELEASE_SETTLE: begin
                    release_settle_reg <= cfg_wdata[TICK_COUNT_WIDTH-1:0];
                end
                bda_pkg::CFG_REPEAT_TICKS: begin
                    repeat_ticks_reg <= cfg_wdata[TICK_COUNT_WIDTH-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign min_value            = min_value_reg;
    assign max_value            = max_value_reg;
    assign press_settle_ticks   = press_settle_reg;
    assign release_settle_ticks = release_settle_reg;
    assign repeat_ticks         = repeat_ticks_reg;

endmodule

>>> hw/rtl/bda_core.sv
// ----------------------------------------------------------------------------
// bda_core
// Debounce state machine, repeat counter and wrapping display counter.
// Updates its state once per step and returns the result of that step.
// ----------------------------------------------------------------------------
module bda_core #(
    parameter int VALUE_WIDTH      = 8,
    parameter int TICK_COUNT_WIDTH = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step_en,
    input  logic                                 req_type,
    input  logic [bda_pkg::CODE_WIDTH-1:0]       pending_code,
    input  logic [bda_pkg::LEVELS_WIDTH-1:0]     button_levels,
    input  logic [VALUE_WIDTH-1:0]               min_value,
    input  logic [VALUE_WIDTH-1:0]               max_value,
    input  logic [TICK_COUNT_WIDTH-1:0]          press_settle_ticks,
    input  logic [TICK_COUNT_WIDTH-1:0]          release_settle_ticks,
    input  logic [TICK_COUNT_WIDTH-1:0]          repeat_ticks,
    output logic [VALUE_WIDTH-1:0]               display_value,
    output bda_pkg::res_flags_t                  res_flags
);

    bda_pkg::mode_t                  mode_reg, mode_next;
    logic [TICK_COUNT_WIDTH-1:0]     settle_reg, settle_next;
    logic [TICK_COUNT_WIDTH-1:0]     repeat_reg, repeat_next;
    logic [bda_pkg::CODE_WIDTH-1:0]  code_reg, code_next;
    logic [VALUE_WIDTH-1:0]          counter_reg, counter_next;
    logic                            next_flag_reg, next_flag_next;

    logic [VALUE_WIDTH:0]            counter_inc;
    logic [VALUE_WIDTH:0]            span;
    logic [VALUE_WIDTH-1:0]          counter_adv;
    logic [TICK_COUNT_WIDTH-1:0]     settle_inc;
    logic [TICK_COUNT_WIDTH-1:0]     repeat_inc;
    logic [bda_pkg::CODE_WIDTH-1:0]  act_code;
    logic                            act_en;

    // counter advance with compare-and-wrap; free run when max is below min
    assign counter_inc = {1'b0, counter_reg} + (VALUE_WIDTH+1)'(1);
    assign span        = {1'b0, max_value} - {1'b0, min_value} + (VALUE_WIDTH+1)'(1);
    assign counter_adv = ((max_value >= min_value) && (counter_inc >= span))
                       ? '0 : counter_inc[VALUE_WIDTH-1:0];

    assign settle_inc = settle_reg + TICK_COUNT_WIDTH'(1);
    assign repeat_inc = repeat_reg + TICK_COUNT_WIDTH'(1);

    always_comb begin
        mode_next   = mode_reg;
        settle_next = settle_reg;
        repeat_next = repeat_reg;
        code_next   = code_reg;
        act_en      = 1'b0;
        act_code    = code_reg;

        if (req_type == bda_pkg::REQ_EDGE) begin
            if (mode_reg == bda_pkg::MODE_IDLE) begin
                code_next   = pending_code;
                act_code    = pending_code;
                act_en      = 1'b1;
                settle_next = '0;
                mode_next   = bda_pkg::MODE_PRESS;
            end
        end else begin
            case (mode_reg)
                bda_pkg::MODE_PRESS: begin
                    if (settle_reg == press_settle_ticks) begin
                        mode_next   = bda_pkg::MODE_HELD;
                        repeat_next = '0;
                    end else begin
                        settle_next = settle_inc;
                    end
                end
                bda_pkg::MODE_HELD: begin
                    if (button_levels != bda_pkg::LEVELS_UP) begin
                        if (repeat_inc == repeat_ticks) begin
                            act_en      = 1'b1;
                            repeat_next = '0;
                        end else begin
                            repeat_next = repeat_inc;
                        end
                    end else begin
                        settle_next = '0;
                        mode_next   = bda_pkg::MODE_RELEASE;
                    end
                end
                bda_pkg::MODE_RELEASE: begin
                    if (settle_reg == release_settle_ticks) begin
                        mode_next = bda_pkg::MODE_IDLE;
                    end else begin
                        settle_next = settle_inc;
                    end
                end
                default: begin
                    // idle ignores ticks
                end
            endcase
        end

        counter_next   = counter_reg;
        next_flag_next = next_flag_reg;
        if (act_en && (act_code == bda_pkg::CODE_INC)) begin
            counter_next = counter_adv;
        end
        if (act_en && (act_code == bda_pkg::CODE_NEXT)) begin
            next_flag_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= bda_pkg::MODE_IDLE;
            settle_reg    <= '0;
            repeat_reg    <= '0;
            code_reg      <= '0;
            counter_reg   <= VALUE_WIDTH'(1);
            next_flag_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg      <= mode_next;
            settle_reg    <= settle_next;
            repeat_reg    <= repeat_next;
            code_reg      <= code_next;
            counter_reg   <= counter_next;
            next_flag_reg <= next_flag_next;
        end
    end

    assign display_value             = counter_next + min_value;
    assign res_flags.display_written = act_en && (act_code == bda_pkg::CODE_INC);
    assign res_flags.next_requested  = next_flag_next;
    assign res_flags.edges_armed     = (mode_next == bda_pkg::MODE_IDLE);

endmodule

>>> hw/rtl/button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Push-button debounce with auto-repeat: edge events and ticks in, one
// display/status beat out per input beat.
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  s_*      | in        | edge event (tuser=0) or tick (tuser=1)
//  m_*      | out       | display value and status flags
//  cfg_*    | in        | register write, no handshake
//
//  An accepted beat lands in the input register; when the core steps, it
//  updates its state and writes the result register. Throughput is one beat
//  per cycle unless m_tready stalls, set by the single state update per step.
//  aresetn is synchronous: it clears both stage valids, the debounce state
//  and loads the register defaults. A stall on m_tready holds the result
//  register and, through s_tready, the input register.
// ----------------------------------------------------------------------------
`include "button_debounce_autorepeat_assert.svh"

module button_debounce_autorepeat #(
    parameter int VALUE_WIDTH      = 8,
    parameter int TICK_COUNT_WIDTH = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // pending_code[3:0], button_levels[5:4]
    input  logic                                 s_tuser,  // req_type
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((VALUE_WIDTH+10)/8)*8-1:0]    m_tdata,  // display_value, display_written,
                                                           // next_requested, edges_armed
    // configuration
    input  logic                                 cfg_we,
    input  logic [bda_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [((VALUE_WIDTH > TICK_COUNT_WIDTH) ? VALUE_WIDTH : TICK_COUNT_WIDTH)-1:0]
                                                 cfg_wdata
);

    localparam int CFG_DATA_WIDTH = (VALUE_WIDTH > TICK_COUNT_WIDTH) ? VALUE_WIDTH
                                                                     : TICK_COUNT_WIDTH;
    localparam int OUT_BITS  = VALUE_WIDTH + 3;
    localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    logic [VALUE_WIDTH-1:0]      min_value;
    logic [VALUE_WIDTH-1:0]      max_value;
    logic [TICK_COUNT_WIDTH-1:0] press_settle_ticks;
    logic [TICK_COUNT_WIDTH-1:0] release_settle_ticks;
    logic [TICK_COUNT_WIDTH-1:0] repeat_ticks;

    logic                               in_valid_reg;
    logic                               in_type_reg;
    logic [bda_pkg::CODE_WIDTH-1:0]     in_code_reg;
    logic [bda_pkg::LEVELS_WIDTH-1:0]   in_levels_reg;

    logic                               out_valid_reg;
    logic [VALUE_WIDTH-1:0]             out_value_reg;
    bda_pkg::res_flags_t                out_flags_reg;

    logic                               step_en;
    logic [VALUE_WIDTH-1:0]             display_value;
    bda_pkg::res_flags_t                res_flags;

    // advance when the result register is free or being drained
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    bda_cfg #(
        .VALUE_WIDTH      (VALUE_WIDTH),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH),
        .CFG_DATA_WIDTH   (CFG_DATA_WIDTH)
    ) u_cfg (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .min_value            (min_value),
        .max_value            (max_value),
        .press_settle_ticks   (press_settle_ticks),
        .release_settle_ticks (release_settle_ticks),
        .repeat_ticks         (repeat_ticks)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg   <= s_tuser;
            in_code_reg   <= s_tdata[3:0];
            in_levels_reg <= s_tdata[5:4];
        end
    end

    bda_core #(
        .VALUE_WIDTH      (VALUE_WIDTH),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .step_en              (step_en),
        .req_type             (in_type_reg),
        .pending_code         (in_code_reg),
        .button_levels        (in_levels_reg),
        .min_value            (min_value),
        .max_value            (max_value),
        .press_settle_ticks   (press_settle_ticks),
        .release_settle_ticks (release_settle_ticks),
        .repeat_ticks         (repeat_ticks),
        .display_value        (display_value),
        .res_flags            (res_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_flags_reg <= '0;
        end else begin
            if (step_en) begin
                out_valid_reg <= 1'b1;
                out_flags_reg <= res_flags;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_value_reg <= display_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_WIDTH'({out_flags_reg.edges_armed,
                                  out_flags_reg.next_requested,
                                  out_flags_reg.display_written,
                                  out_value_reg});

    // a stepped beat always shows up in the result register
    `BDA_ASSERT_NEXT(a_step_fills_out, aclk, aresetn, step_en, out_valid_reg)

    // a beat held in the input register is not lost while the output stalls
    `BDA_ASSERT_NEXT(a_in_held_on_stall, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_tready, in_valid_reg)

    // the next flag is sticky across results
    `BDA_ASSERT_NEXT(a_next_sticky, aclk, aresetn,
        out_flags_reg.next_requested, out_flags_reg.next_requested)

    // an advanced display is only reported with a valid result
    `BDA_ASSERT_NOW(a_written_has_beat, aclk, aresetn,
        out_flags_reg.display_written && !out_valid_reg, !$past(step_en) || !aresetn)

endmodule
